// ===== rtl/core/pse_pkg.sv =====
package pse_pkg;

  // Gaps at or below this many microseconds are treated as a restart.
  localparam int MIN_GAP_US = 100;

  // Shared multiplier operand width, product is twice as wide.
  localparam int MUL_W = 34;

  // Divider: dividend magnitude bits and divisor bits.
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 34;

  // CORDIC vector and angle widths.
  localparam int CORDIC_XW = 40;
  localparam int CORDIC_ZW = 34;
  localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 40'sd652032874;
  localparam logic signed [CORDIC_ZW-1:0] QUARTER = 34'sd1073741824;

  // Configuration register indexes.
  localparam logic [2:0] CFG_POSE_TC  = 3'd0;
  localparam logic [2:0] CFG_VEL_TAU  = 3'd1;
  localparam logic [2:0] CFG_MAX_GAP  = 3'd2;
  localparam logic [2:0] CFG_HDG_OFF  = 3'd3;
  localparam logic [2:0] CFG_VEL_EN   = 3'd4;

  localparam logic [23:0] MAX_GAP_FLOOR = 24'd20000;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    case (idx)
      5'd0:  return 30'd536870912;
      5'd1:  return 30'd316933406;
      5'd2:  return 30'd167458907;
      5'd3:  return 30'd85004756;
      5'd4:  return 30'd42667331;
      5'd5:  return 30'd21354465;
      5'd6:  return 30'd10679838;
      5'd7:  return 30'd5340245;
      5'd8:  return 30'd2670163;
      5'd9:  return 30'd1335087;
      5'd10: return 30'd667544;
      5'd11: return 30'd333772;
      5'd12: return 30'd166886;
      5'd13: return 30'd83443;
      5'd14: return 30'd41722;
      5'd15: return 30'd20861;
      5'd16: return 30'd10430;
      5'd17: return 30'd5215;
      5'd18: return 30'd2608;
      5'd19: return 30'd1304;
      5'd20: return 30'd652;
      5'd21: return 30'd326;
      5'd22: return 30'd163;
      5'd23: return 30'd81;
      default: return 30'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [15:0] q30_to_q15(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = (v + 40'sd16384) >>> 15;
    if (t > 40'sd32767) begin
      return 16'sh7FFF;
    end else if (t < -40'sd32768) begin
      return 16'sh8000;
    end else begin
      return t[15:0];
    end
  endfunction

endpackage

// ===== rtl/core/pose_smoother_velocity_estimator.sv =====
// Pose smoother and body-velocity estimator.
// The input channel (in_valid/in_stall) carries one timestamped map pose per
// item; the output channel (out_valid/out_stall) returns exactly one result
// item per input item, in order. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); the user must write it only while the block
// is idle, and the block itself does not enforce this. Each item runs through
// a small sequencer that reuses one 34x34 multiplier, one iterative CORDIC
// unit and one bit-serial rounding divider. The divider sets the pace: an
// item needs up to ten divisions (four for the pose filter, three for the
// map velocity, three for the velocity filter). A CORDIC pass runs two or
// three times per item. in_stall is high from acceptance until the result is
// placed in the output register, so one item is worked on at a time.
// The output register holds a finished result while the receiver stalls;
// the next item is already accepted and worked on, and it only waits at the
// end if the previous result has still not been taken.
// Reset is synchronous: the filters lose their history, the registers return
// to their defaults and no result is pending.
module pose_smoother_velocity_estimator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [39:0]        stamp_us,
  input  logic signed [31:0] trans_x,
  input  logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic signed [15:0] quat_in_x,
  input  logic signed [15:0] quat_in_y,
  input  logic signed [15:0] quat_in_z,
  input  logic signed [15:0] quat_in_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [15:0] out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [31:0] body_vel_x,
  output logic signed [31:0] body_vel_y,
  output logic signed [31:0] turn_rate,
  output logic               velocity_valid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import pse_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_Q0    = 5'd1;
  localparam logic [4:0] ST_Q1    = 5'd2;
  localparam logic [4:0] ST_Q2    = 5'd3;
  localparam logic [4:0] ST_Q3    = 5'd4;
  localparam logic [4:0] ST_Q4    = 5'd5;
  localparam logic [4:0] ST_ATAN  = 5'd6;
  localparam logic [4:0] ST_HIN   = 5'd7;
  localparam logic [4:0] ST_PMUL  = 5'd8;
  localparam logic [4:0] ST_PDIV  = 5'd9;
  localparam logic [4:0] ST_VCHK  = 5'd10;
  localparam logic [4:0] ST_VDEN  = 5'd11;
  localparam logic [4:0] ST_VDEN2 = 5'd12;
  localparam logic [4:0] ST_VMUL  = 5'd13;
  localparam logic [4:0] ST_VDIV  = 5'd14;
  localparam logic [4:0] ST_VSC   = 5'd15;
  localparam logic [4:0] ST_B0    = 5'd16;
  localparam logic [4:0] ST_B1    = 5'd17;
  localparam logic [4:0] ST_B2    = 5'd18;
  localparam logic [4:0] ST_B3    = 5'd19;
  localparam logic [4:0] ST_B4    = 5'd20;
  localparam logic [4:0] ST_VLMUL = 5'd21;
  localparam logic [4:0] ST_VLDIV = 5'd22;
  localparam logic [4:0] ST_VEND  = 5'd23;
  localparam logic [4:0] ST_OSC   = 5'd24;
  localparam logic [4:0] ST_OUT   = 5'd25;

  // Configuration.
  logic [23:0] pose_tc, vel_tau, max_gap;
  logic [15:0] hdg_off;
  logic vel_en;

  // Filter history.
  logic pose_ready, have_previous, vel_ready;
  logic signed [31:0] smooth_x, smooth_y, smooth_z;
  logic signed [15:0] smooth_heading, previous_heading;
  logic [39:0] last_filter_stamp, previous_stamp;
  logic signed [31:0] previous_x, previous_y;
  logic signed [31:0] vel_x_state, vel_y_state, rate_state;

  // Working registers of the current item.
  logic [4:0] state;
  logic [1:0] k;
  logic [39:0] stamp_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r, h_in;
  logic signed [33:0] acc_a, acc_b, rden;
  logic [24:0] dt_r, dtv_r;
  logic signed [31:0] mx, my, rate_tgt, bx, by;
  logic signed [39:0] cos_r, sin_r;
  logic signed [67:0] prod, t_prod;
  logic cor_wait, div_wait;

  // Shared multiplier.
  logic signed [MUL_W-1:0] mul_a, mul_b;

  // Unit connections.
  logic cor_start, cor_vec, cor_done, div_start, div_done;
  logic signed [CORDIC_XW-1:0] cor_x_in, cor_y_in, cor_x, cor_y;
  logic signed [CORDIC_ZW-1:0] cor_z_in, cor_z, hz;
  logic signed [DIV_NW:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  logic signed [39:0] dtp, dtv;
  logic signed [15:0] hd_pose, hd_vel;
  logic [15:0] h_calc;
  logic signed [31:0] px_in;
  logic load_pose, gap_pose, dtv_ok;
  logic signed [67:0] b_sum;

  assign in_stall = (state != ST_IDLE);

  assign dtp     = signed'(stamp_r - last_filter_stamp);
  assign dtv     = signed'(stamp_r - previous_stamp);
  assign hd_pose = h_in - smooth_heading;
  assign hd_vel  = smooth_heading - previous_heading;
  assign hz      = cor_z + 34'sd32768;
  // The arctangent is rounded to a 16-bit angle, then turned a quarter turn
  // and by the configured offset.
  assign h_calc  = hz[31:16] + 16'h4000 + hdg_off;
  assign px_in   = (trans_y == 32'sh80000000) ? 32'sh7FFFFFFF : -trans_y;

  assign load_pose = (pose_tc == 24'd0) || !pose_ready;
  assign gap_pose  = (dtp <= signed'(40'(MIN_GAP_US))) || (dtp > signed'({16'b0, max_gap}));
  assign dtv_ok    = (dtv > signed'(40'(MIN_GAP_US))) && (dtv <= signed'({16'b0, max_gap}));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_Q0: begin
        mul_a = 34'(qw_r);
        mul_b = 34'(qz_r);
      end
      ST_Q1: begin
        mul_a = 34'(qx_r);
        mul_b = 34'(qy_r);
      end
      ST_Q2: begin
        mul_a = 34'(qy_r);
        mul_b = 34'(qy_r);
      end
      ST_Q3: begin
        mul_a = 34'(qz_r);
        mul_b = 34'(qz_r);
      end
      ST_PMUL: begin
        mul_b = signed'({9'b0, dt_r});
        case (k)
          2'd0: mul_a = 34'(px_r) - 34'(smooth_x);
          2'd1: mul_a = 34'(py_r) - 34'(smooth_y);
          2'd2: mul_a = 34'(pz_r) - 34'(smooth_z);
          default: mul_a = 34'(hd_pose);
        endcase
      end
      ST_VDEN: begin
        mul_a = signed'({9'b0, dtv_r});
        mul_b = 34'sd1000;
      end
      ST_VMUL: begin
        case (k)
          2'd0: begin
            mul_a = 34'(smooth_x) - 34'(previous_x);
            mul_b = 34'sd1000000;
          end
          2'd1: begin
            mul_a = 34'(smooth_y) - 34'(previous_y);
            mul_b = 34'sd1000000;
          end
          default: begin
            // Two pi scaled by 10^9, divided later by 1000 dt.
            mul_a = 34'(hd_vel);
            mul_b = 34'sd6283185307;
          end
        endcase
      end
      ST_B0: begin
        mul_a = cos_r[33:0];
        mul_b = 34'(mx);
      end
      ST_B1: begin
        mul_a = sin_r[33:0];
        mul_b = 34'(my);
      end
      ST_B2: begin
        mul_a = cos_r[33:0];
        mul_b = 34'(my);
      end
      ST_B3: begin
        mul_a = sin_r[33:0];
        mul_b = 34'(mx);
      end
      ST_VLMUL: begin
        mul_b = signed'({9'b0, dtv_r});
        case (k)
          2'd0: mul_a = 34'(bx) - 34'(vel_x_state);
          2'd1: mul_a = 34'(by) - 34'(vel_y_state);
          default: mul_a = 34'(rate_tgt) - 34'(rate_state);
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // CORDIC requests: arctangent of the quaternion yaw, then sine and cosine of
  // the full heading for the body rotation and of the half heading for output.
  assign cor_start = ((state == ST_ATAN) || (state == ST_VSC) || (state == ST_OSC)) && !cor_wait;
  assign cor_vec   = (state == ST_ATAN);
  assign cor_x_in  = 40'sd1073741824 - {{5{acc_b[33]}}, acc_b, 1'b0};
  assign cor_y_in  = {{5{acc_a[33]}}, acc_a, 1'b0};
  assign cor_z_in  = (state == ST_VSC) ? {{2{smooth_heading[15]}}, smooth_heading, 16'b0}
                                       : {{3{smooth_heading[15]}}, smooth_heading, 15'b0};

  pse_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .vec   (cor_vec),
    .x_in  (cor_x_in),
    .y_in  (cor_y_in),
    .z_in  (cor_z_in),
    .x_out (cor_x),
    .y_out (cor_y),
    .z_out (cor_z),
    .done  (cor_done)
  );

  // Division requests. The numerator is always the product of the previous
  // multiply step, captured on the first cycle of the divide state.
  assign div_start = ((state == ST_PDIV) || (state == ST_VDIV) || (state == ST_VLDIV))
                     && !div_wait;
  assign div_num   = prod[DIV_NW:0];

  always_comb begin
    case (state)
      ST_PDIV:  div_den = 34'(pose_tc) + 34'(dt_r);
      ST_VDIV:  div_den = (k == 2'd2) ? rden : 34'(dtv_r);
      default:  div_den = 34'(vel_tau) + 34'(dtv_r);
    endcase
  end

  pse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign b_sum = (state == ST_B2) ? (t_prod + prod + 68'sd536870912)
                                  : (t_prod - prod + 68'sd536870912);

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_tc  <= 24'd100000;
      vel_tau  <= 24'd250000;
      max_gap  <= 24'd500000;
      hdg_off  <= 16'd0;
      vel_en   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POSE_TC:  pose_tc <= cfg_data;
        CFG_VEL_TAU:  vel_tau <= cfg_data;
        CFG_MAX_GAP:  max_gap <= (cfg_data < MAX_GAP_FLOOR) ? MAX_GAP_FLOOR : cfg_data;
        CFG_HDG_OFF:  hdg_off <= cfg_data[15:0];
        CFG_VEL_EN:   vel_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      stamp_r <= stamp_us;
      px_r    <= px_in;
      py_r    <= trans_x;
      pz_r    <= trans_z;
      qx_r    <= quat_in_x;
      qy_r    <= quat_in_y;
      qz_r    <= quat_in_z;
      qw_r    <= quat_in_w;
    end
  end

  // Sequencer with the filter history it updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      k                 <= '0;
      cor_wait          <= 1'b0;
      div_wait          <= 1'b0;
      out_valid         <= 1'b0;
      pose_ready        <= 1'b0;
      have_previous     <= 1'b0;
      vel_ready         <= 1'b0;
      smooth_x          <= '0;
      smooth_y          <= '0;
      smooth_z          <= '0;
      smooth_heading    <= '0;
      last_filter_stamp <= '0;
      previous_x        <= '0;
      previous_y        <= '0;
      previous_heading  <= '0;
      previous_stamp    <= '0;
      vel_x_state       <= '0;
      vel_y_state       <= '0;
      rate_state        <= '0;
    end else begin
      // A new result enters the output register, or the held one leaves.
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cor_start) begin
        cor_wait <= 1'b1;
      end else if (cor_done) begin
        cor_wait <= 1'b0;
      end
      if (div_start) begin
        div_wait <= 1'b1;
      end else if (div_done) begin
        div_wait <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_Q0;
          end
        end
        ST_Q0: state <= ST_Q1;
        ST_Q1: begin
          acc_a <= prod[33:0];
          state <= ST_Q2;
        end
        ST_Q2: begin
          acc_a <= acc_a + prod[33:0];
          state <= ST_Q3;
        end
        ST_Q3: begin
          acc_b <= prod[33:0];
          state <= ST_Q4;
        end
        ST_Q4: begin
          acc_b <= acc_b + prod[33:0];
          state <= ST_ATAN;
        end
        ST_ATAN: begin
          if (cor_done) begin
            state <= ST_HIN;
          end
        end
        ST_HIN: begin
          h_in              <= signed'(h_calc);
          dt_r              <= dtp[24:0];
          last_filter_stamp <= stamp_r;
          pose_ready        <= 1'b1;
          k                 <= '0;
          if (load_pose || gap_pose) begin
            smooth_x       <= px_r;
            smooth_y       <= py_r;
            smooth_z       <= pz_r;
            smooth_heading <= signed'(h_calc);
            if (!load_pose) begin
              vel_x_state <= '0;
              vel_y_state <= '0;
              rate_state  <= '0;
              vel_ready   <= 1'b0;
            end
            state <= ST_VCHK;
          end else begin
            state <= ST_PMUL;
          end
        end
        ST_PMUL: state <= ST_PDIV;
        ST_PDIV: begin
          if (div_done) begin
            case (k)
              2'd0: smooth_x <= sat32(68'(smooth_x) + 68'(div_quo));
              2'd1: smooth_y <= sat32(68'(smooth_y) + 68'(div_quo));
              2'd2: smooth_z <= sat32(68'(smooth_z) + 68'(div_quo));
              default: smooth_heading <= smooth_heading + div_quo[15:0];
            endcase
            if (k == 2'd3) begin
              state <= ST_VCHK;
            end else begin
              k     <= k + 1'b1;
              state <= ST_PMUL;
            end
          end
        end
        ST_VCHK: begin
          dtv_r <= dtv[24:0];
          k     <= '0;
          if (!vel_en) begin
            state <= ST_OSC;
          end else if (!have_previous) begin
            state <= ST_VEND;
          end else if (!dtv_ok) begin
            vel_x_state <= '0;
            vel_y_state <= '0;
            rate_state  <= '0;
            vel_ready   <= 1'b0;
            state       <= ST_VEND;
          end else begin
            state <= ST_VDEN;
          end
        end
        ST_VDEN: state <= ST_VDEN2;
        ST_VDEN2: begin
          rden  <= prod[33:0];
          state <= ST_VMUL;
        end
        ST_VMUL: state <= ST_VDIV;
        ST_VDIV: begin
          if (div_done) begin
            case (k)
              2'd0: mx <= sat32(68'(div_quo));
              2'd1: my <= sat32(68'(div_quo));
              default: rate_tgt <= sat32(68'(div_quo));
            endcase
            if (k == 2'd2) begin
              state <= ST_VSC;
            end else begin
              k     <= k + 1'b1;
              state <= ST_VMUL;
            end
          end
        end
        ST_VSC: begin
          if (cor_done) begin
            cos_r <= cor_x;
            sin_r <= cor_y;
            state <= ST_B0;
          end
        end
        ST_B0: state <= ST_B1;
        ST_B1: begin
          t_prod <= prod;
          state  <= ST_B2;
        end
        ST_B2: begin
          bx    <= sat32(b_sum >>> 30);
          state <= ST_B3;
        end
        ST_B3: begin
          t_prod <= prod;
          state  <= ST_B4;
        end
        ST_B4: begin
          by <= sat32(b_sum >>> 30);
          k  <= '0;
          if (vel_tau == 24'd0) begin
            vel_x_state <= bx;
            vel_y_state <= sat32(b_sum >>> 30);
            rate_state  <= rate_tgt;
            vel_ready   <= 1'b1;
            state       <= ST_VEND;
          end else begin
            state <= ST_VLMUL;
          end
        end
        ST_VLMUL: state <= ST_VLDIV;
        ST_VLDIV: begin
          if (div_done) begin
            case (k)
              2'd0: vel_x_state <= sat32(68'(vel_x_state) + 68'(div_quo));
              2'd1: vel_y_state <= sat32(68'(vel_y_state) + 68'(div_quo));
              default: rate_state <= sat32(68'(rate_state) + 68'(div_quo));
            endcase
            if (k == 2'd2) begin
              vel_ready <= 1'b1;
              state     <= ST_VEND;
            end else begin
              k     <= k + 1'b1;
              state <= ST_VLMUL;
            end
          end
        end
        ST_VEND: begin
          previous_x       <= smooth_x;
          previous_y       <= smooth_y;
          previous_heading <= smooth_heading;
          previous_stamp   <= stamp_r;
          have_previous    <= 1'b1;
          state            <= ST_OSC;
        end
        ST_OSC: begin
          if (cor_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register; loaded when the previous result is gone or leaving.
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      out_x          <= smooth_x;
      out_y          <= smooth_y;
      out_z          <= smooth_z;
      out_heading    <= smooth_heading;
      out_quat_z     <= q30_to_q15(cor_y);
      out_quat_w     <= q30_to_q15(cor_x);
      body_vel_x     <= (vel_en && vel_ready) ? vel_x_state : '0;
      body_vel_y     <= (vel_en && vel_ready) ? vel_y_state : '0;
      turn_rate      <= (vel_en && vel_ready) ? rate_state : '0;
      velocity_valid <= vel_en && vel_ready;
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(div_start && cor_start))
    else $error("divider and CORDIC started together");

  a_result_has_pose: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pose_ready)
    else $error("result pending without a loaded pose");

  a_vel_needs_prev: assert property (@(posedge clk) disable iff (rst)
    vel_ready |-> have_previous)
    else $error("velocity estimate without a previous pose");

endmodule

// ===== rtl/core/pse_cordic.sv =====
module pse_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   vec,
  input  logic signed [pse_pkg::CORDIC_XW-1:0]   x_in,
  input  logic signed [pse_pkg::CORDIC_XW-1:0]   y_in,
  input  logic signed [pse_pkg::CORDIC_ZW-1:0]   z_in,
  output logic signed [pse_pkg::CORDIC_XW-1:0]   x_out,
  output logic signed [pse_pkg::CORDIC_XW-1:0]   y_out,
  output logic signed [pse_pkg::CORDIC_ZW-1:0]   z_out,
  output logic                                   done
);
  import pse_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic signed [CORDIC_XW-1:0] x, y, xs, ys;
  logic signed [CORDIC_ZW-1:0] z, t, az;
  logic [IW-1:0] i;
  logic busy, vec_r, flip, zero, up;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign t  = signed'({4'b0, atan_entry(5'(i))});
  // Vectoring drives y toward zero, rotation drives the residual angle to zero.
  assign up = vec_r ? (y > 0) : (z < 0);
  assign az = z_in + 34'sd2147483648;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        if (i == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec_r <= vec;
      if (vec) begin
        flip <= 1'b0;
        zero <= (x_in == 0) && (y_in == 0);
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x <= y_in;
            y <= -x_in;
            z <= QUARTER;
          end else begin
            x <= -y_in;
            y <= x_in;
            z <= -QUARTER;
          end
        end else begin
          x <= x_in;
          y <= y_in;
          z <= '0;
        end
      end else begin
        zero <= 1'b0;
        x    <= CORDIC_X0;
        y    <= '0;
        // Angles beyond a quarter turn are turned by a half turn first.
        if (z_in > QUARTER || z_in < -QUARTER) begin
          flip <= 1'b1;
          z    <= {{2{az[31]}}, az[31:0]};
        end else begin
          flip <= 1'b0;
          z    <= z_in;
        end
      end
    end else if (busy) begin
      if (up) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + t;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end
    end
  end

  assign x_out = flip ? -x : x;
  assign y_out = flip ? -y : y;
  assign z_out = zero ? '0 : z;

endmodule

// ===== rtl/core/pse_div.sv =====
module pse_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pse_pkg::DIV_NW:0]      num,
  input  logic [pse_pkg::DIV_DW-1:0]           den,
  output logic signed [pse_pkg::DIV_NW:0]      quo,
  output logic                                 done
);
  import pse_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] dvd, mag;
  logic [DIV_DW-1:0] rem, den_r;
  logic [DIV_DW:0] r2;
  logic [CW-1:0] cnt;
  logic busy, neg, fits;

  assign mag  = num[DIV_NW] ? DIV_NW'(-num) : num[DIV_NW-1:0];
  assign r2   = {rem, dvd[DIV_NW-1]};
  assign fits = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle; half the divisor is added
  // up front so the quotient rounds to nearest with halves away from zero.
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[DIV_NW];
      den_r <= den;
      rem   <= '0;
      dvd   <= mag + DIV_NW'(den >> 1);
    end else if (busy) begin
      rem <= fits ? DIV_DW'(r2 - {1'b0, den_r}) : r2[DIV_DW-1:0];
      dvd <= {dvd[DIV_NW-2:0], fits};
    end
  end

  assign quo = neg ? -signed'({1'b0, dvd}) : signed'({1'b0, dvd});

endmodule
